>>> sv/ffba_pkg.sv
// shared types and constants of the first-fit block allocator
// no dependencies
`timescale 1ns / 1ps

package ffba_pkg;

    localparam int REGION_W     = 17;
    localparam int SIZE_W       = 16;
    localparam int ADDR_W       = 16;
    localparam int USED_W       = 17;
    localparam int WORD_BYTES   = 8;
    localparam int HEADER_BYTES = 10;
    localparam int ENTRY_W      = 2 + SIZE_W;
    localparam logic [REGION_W-1:0] REGION_RESET = 17'd65536;

    typedef enum logic [0:0] {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        RSP_OK       = 2'd0,
        RSP_ZERO     = 2'd1,
        RSP_NO_SPACE = 2'd2,
        RSP_BAD_FREE = 2'd3
    } t_rsp_status;

    typedef enum logic [1:0] {
        BLK_NEVER = 2'd0,
        BLK_FREED = 2'd1,
        BLK_INUSE = 2'd2
    } t_blk_state;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_APPEND,
        S_OUT
    } t_state;

endpackage

>>> sv/ffba_if.sv
// handshake channels of the allocator: request, response, configuration
// depends on ffba_pkg
`timescale 1ns / 1ps

interface ffba_req_if;
    import ffba_pkg::*;
    logic                valid;
    logic                ready;
    logic                action;
    logic [SIZE_W-1:0]   request_size;
    logic [ADDR_W-1:0]   block_address;
    modport source (output valid, action, request_size, block_address, input ready);
    modport sink   (input valid, action, request_size, block_address, output ready);
endinterface

interface ffba_rsp_if;
    import ffba_pkg::*;
    logic                valid;
    logic                ready;
    logic [ADDR_W-1:0]   payload_offset;
    logic [1:0]          status;
    logic [USED_W-1:0]   used_bytes;
    modport source (output valid, payload_offset, status, used_bytes, input ready);
    modport sink   (input valid, payload_offset, status, used_bytes, output ready);
endinterface

interface ffba_cfg_if;
    import ffba_pkg::*;
    logic                valid;
    logic                ready;
    logic [REGION_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> sv/first_fit_block_allocator.sv
// operation: allocate or free walks the block table one entry per cycle from a single-port
//   synchronous memory; an allocate with no fitting freed block then appends, and every
//   result is held in an output register; zero-size allocate and null free skip the walk
// one request at a time: a new request is taken only in the idle state
// reset: block count and used bytes cleared, region length 65536; the table is not swept,
//   entries past the block count are never used
`timescale 1ns / 1ps

module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int MEM_BYTES  = 65536,
    parameter int MAX_BLOCKS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ffba_cfg_if.sink    i_cfg,
    ffba_req_if.sink    i_req,
    ffba_rsp_if.source  o_rsp
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = IDX_W + 1;
    localparam int OFF_W = IDX_W + 18;
    localparam int CMP_W = ((OFF_W > 25) ? OFF_W : 25) + 1;

    // block table: {state, kept size}
    logic [ENTRY_W-1:0] r_mem [MAX_BLOCKS];
    logic [ENTRY_W-1:0] r_rdata;

    t_state              r_state, n_state;
    logic [REGION_W-1:0] r_region;
    logic [CNT_W-1:0]    r_count;
    logic [USED_W-1:0]   r_used;
    t_action             r_act;
    logic [SIZE_W-1:0]   r_n;
    logic [ADDR_W-1:0]   r_addr;
    logic [OFF_W-1:0]    r_off;
    logic [IDX_W-1:0]    r_idx;
    logic [ADDR_W-1:0]   r_res_payload;
    t_rsp_status         r_res_status;
    logic [USED_W-1:0]   r_res_used;
    logic                r_o_valid;
    logic [ADDR_W-1:0]   r_o_payload;
    t_rsp_status         r_o_status;
    logic [USED_W-1:0]   r_o_used;

    logic               w_accept;
    logic               w_out_free;
    logic [SIZE_W-1:0]  w_size;
    t_blk_state         w_bstate;
    logic [OFF_W-1:0]   w_hdr_end;
    logic [OFF_W-1:0]   w_next_off;
    logic               w_alloc_hit;
    logic               w_free_match;
    logic               w_last;
    logic [CMP_W-1:0]   w_need;
    logic [CMP_W-1:0]   w_limit;
    logic               w_fits;
    logic [USED_W:0]    w_free_amt;
    logic               w_rd_en;
    logic [IDX_W-1:0]   w_rd_addr;
    logic               w_wr_en;
    logic [IDX_W-1:0]   w_wr_addr;
    logic [ENTRY_W-1:0] w_wr_data;

    assign w_accept   = i_req.valid && i_req.ready;
    assign w_out_free = !r_o_valid || o_rsp.ready;

    assign w_size     = r_rdata[SIZE_W-1:0];
    assign w_bstate   = t_blk_state'(r_rdata[ENTRY_W-1:SIZE_W]);
    assign w_hdr_end  = r_off + OFF_W'(HEADER_BYTES);
    assign w_next_off = w_hdr_end + OFF_W'(w_size);
    assign w_alloc_hit  = (r_act == ACT_ALLOC) && (w_bstate == BLK_FREED) && (w_size >= r_n);
    assign w_free_match = (r_act == ACT_FREE) && (w_hdr_end == OFF_W'(r_addr));
    assign w_last     = (CNT_W'(r_idx) + CNT_W'(1)) == r_count;

    // append check against the region, clamped to the memory size, and against the table depth
    assign w_need  = CMP_W'(r_off) + CMP_W'(HEADER_BYTES) + CMP_W'(r_n);
    assign w_limit = (CMP_W'(r_region) > CMP_W'(MEM_BYTES)) ? CMP_W'(MEM_BYTES)
                                                             : CMP_W'(r_region);
    assign w_fits  = (r_count < CNT_W'(MAX_BLOCKS)) && (w_need <= w_limit);
    assign w_free_amt = (USED_W+1)'(w_size) + (USED_W+1)'(HEADER_BYTES);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_req.action == ACT_ALLOC) begin
                        if (i_req.request_size == '0) begin
                            n_state = S_OUT;
                        end else if (r_count == '0) begin
                            n_state = S_APPEND;
                        end else begin
                            n_state = S_WALK;
                        end
                    end else begin
                        if (i_req.block_address == '0 || r_count == '0) begin
                            n_state = S_OUT;
                        end else begin
                            n_state = S_WALK;
                        end
                    end
                end
            end
            S_WALK: begin
                priority if (w_alloc_hit || w_free_match) begin
                    n_state = S_OUT;
                end else if (w_last) begin
                    n_state = (r_act == ACT_ALLOC) ? S_APPEND : S_OUT;
                end
            end
            S_APPEND: n_state = S_OUT;
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        i_req.ready = (r_state == S_IDLE);
        i_cfg.ready = 1'b1;
        w_rd_en     = 1'b0;
        w_rd_addr   = r_idx + IDX_W'(1);
        w_wr_en     = 1'b0;
        w_wr_addr   = r_idx;
        w_wr_data   = {BLK_INUSE, w_size};
        unique case (r_state)
            S_IDLE: begin
                w_rd_en   = w_accept;
                w_rd_addr = '0;
            end
            S_WALK: begin
                w_rd_en = !(w_alloc_hit || w_free_match || w_last);
                if (w_alloc_hit) begin
                    w_wr_en = 1'b1;
                end else if (w_free_match && w_bstate == BLK_INUSE) begin
                    w_wr_en   = 1'b1;
                    w_wr_data = {BLK_FREED, w_size};
                end
            end
            S_APPEND: begin
                w_wr_en   = w_fits;
                w_wr_addr = r_count[IDX_W-1:0];
                w_wr_data = {BLK_INUSE, r_n};
            end
            S_OUT: ;
            default: ;
        endcase
    end

    // table memory
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_region  <= REGION_RESET;
            r_count   <= '0;
            r_used    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_region <= i_cfg.data;
            end
            if (r_state == S_WALK && w_alloc_hit) begin
                r_used <= r_used + USED_W'(w_size) + USED_W'(HEADER_BYTES);
            end else if (r_state == S_WALK && w_free_match && w_bstate == BLK_INUSE) begin
                r_used <= ((USED_W+1)'(r_used) >= w_free_amt)
                          ? USED_W'((USED_W+1)'(r_used) - w_free_amt) : '0;
            end else if (r_state == S_APPEND && w_fits) begin
                r_used  <= r_used + USED_W'(r_n) + USED_W'(HEADER_BYTES);
                r_count <= r_count + CNT_W'(1);
            end
            if (r_state == S_OUT && w_out_free) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_act         <= t_action'(i_req.action);
                    r_n           <= i_req.request_size;
                    r_addr        <= i_req.block_address;
                    r_off         <= OFF_W'(WORD_BYTES);
                    r_idx         <= '0;
                    r_res_payload <= '0;
                    r_res_used    <= r_used;
                    if (i_req.action == ACT_ALLOC) begin
                        r_res_status <= (i_req.request_size == '0) ? RSP_ZERO : RSP_OK;
                    end else begin
                        r_res_status <= (i_req.block_address != '0 && r_count == '0)
                                        ? RSP_BAD_FREE : RSP_OK;
                    end
                end
            end
            S_WALK: begin
                priority if (w_alloc_hit) begin
                    r_res_payload <= w_hdr_end[ADDR_W-1:0];
                    r_res_status  <= RSP_OK;
                    r_res_used    <= r_used + USED_W'(w_size) + USED_W'(HEADER_BYTES);
                end else if (w_free_match) begin
                    r_res_payload <= '0;
                    if (w_bstate == BLK_INUSE) begin
                        r_res_status <= RSP_OK;
                        r_res_used   <= ((USED_W+1)'(r_used) >= w_free_amt)
                                        ? USED_W'((USED_W+1)'(r_used) - w_free_amt) : '0;
                    end else begin
                        r_res_status <= RSP_BAD_FREE;
                        r_res_used   <= r_used;
                    end
                end else begin
                    r_off         <= w_next_off;
                    r_idx         <= r_idx + IDX_W'(1);
                    r_res_payload <= '0;
                    r_res_status  <= RSP_BAD_FREE;
                    r_res_used    <= r_used;
                end
            end
            S_APPEND: begin
                if (w_fits) begin
                    r_res_payload <= w_hdr_end[ADDR_W-1:0];
                    r_res_status  <= RSP_OK;
                    r_res_used    <= r_used + USED_W'(r_n) + USED_W'(HEADER_BYTES);
                end else begin
                    r_res_payload <= '0;
                    r_res_status  <= RSP_NO_SPACE;
                    r_res_used    <= r_used;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    r_o_payload <= r_res_payload;
                    r_o_status  <= r_res_status;
                    r_o_used    <= r_res_used;
                end
            end
            default: ;
        endcase
    end

    assign o_rsp.valid          = r_o_valid;
    assign o_rsp.payload_offset = r_o_payload;
    assign o_rsp.status         = r_o_status;
    assign o_rsp.used_bytes     = r_o_used;

    // table writes only come from the walk or the append step
    a_wr_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (r_state == S_WALK || r_state == S_APPEND))
        else $error("table write outside walk or append");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_BLOCKS))
        else $error("block count beyond table depth");

    // an append grows the block count by exactly one
    a_append_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPEND && w_fits) |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("append did not bump block count");

    // a response whose status is not OK never carries an offset
    a_fail_no_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != RSP_OK) |-> o_rsp.payload_offset == '0)
        else $error("failed response with nonzero offset");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state != S_IDLE)
        else $error("accepted request left no work");

endmodule
